// ----- hdl/dfa_lexer_with_symbol_table_defines.svh -----
// Assertion macros for the lexer block.
`ifndef DFA_LEXER_WITH_SYMBOL_TABLE_DEFINES_SVH
`define DFA_LEXER_WITH_SYMBOL_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define DLX_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dfa lexer check failed");
`define DLX_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dfa lexer sequence check failed");
`else
`define DLX_ASSERT(lbl, prop)
`define DLX_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- hdl/dlx_pkg.sv -----
package dlx_pkg;

    localparam int MAX_TOKEN_CHARS = 19;
    localparam int IDENT_ENTRIES   = 64;
    localparam int LEN_W   = $clog2(MAX_TOKEN_CHARS + 1);
    localparam int IDX_W   = $clog2(IDENT_ENTRIES);
    localparam int CNT_W   = $clog2(IDENT_ENTRIES + 1);
    localparam int ENTRY_W = MAX_TOKEN_CHARS * 8 + LEN_W;
    localparam int KW_COUNT    = 22;
    localparam int PUNCT_COUNT = 20;

    localparam logic [2:0] CLS_KEYWORD = 3'd0;
    localparam logic [2:0] CLS_PUNCT   = 3'd1;
    localparam logic [2:0] CLS_IDENT   = 3'd2;
    localparam logic [2:0] CLS_NUMBER  = 3'd3;
    localparam logic [2:0] CLS_CHAR    = 3'd4;
    localparam logic [2:0] CLS_STRING  = 3'd5;
    localparam logic [2:0] CLS_ERROR   = 3'd6;

    localparam logic [5:0] DS_REJECT   = 6'd0;
    localparam logic [5:0] DS_START    = 6'd1;
    localparam logic [5:0] DS_IDENT    = 6'd2;
    localparam logic [5:0] DS_INT      = 6'd3;
    localparam logic [5:0] DS_FRAC     = 6'd7;
    localparam logic [5:0] DS_CHAR_END = 6'd16;
    localparam logic [5:0] DS_STR_END  = 6'd17;

    localparam logic [4:0] K_SPACE = 5'd0;
    localparam logic [4:0] K_NONE  = 5'd31;

    localparam logic [7:0] END_MARK = 8'h23;

    function automatic logic [4:0] char_class(input logic [7:0] c);
        logic [4:0] k;
        k = K_NONE;
        case (c)
            8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B: k = K_SPACE;
            ">": k = 5'd3;
            "<": k = 5'd4;
            "=": k = 5'd5;
            8'h22: k = 5'd6;
            "'": k = 5'd7;
            ":": k = 5'd8;
            ",": k = 5'd9;
            ".": k = 5'd10;
            "/": k = 5'd11;
            "?": k = 5'd12;
            "[": k = 5'd13;
            "]": k = 5'd14;
            "{": k = 5'd15;
            "}": k = 5'd16;
            8'h5C: k = 5'd17;
            "|": k = 5'd18;
            "!": k = 5'd19;
            "%": k = 5'd20;
            "^": k = 5'd21;
            "&": k = 5'd22;
            "*": k = 5'd23;
            "+": k = 5'd24;
            "-": k = 5'd25;
            ";": k = 5'd26;
            "(": k = 5'd27;
            ")": k = 5'd28;
            default:
            begin
                if ((c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}))
                begin
                    k = 5'd1;
                end
                else if (c inside {[8'h30:8'h39]})
                begin
                    k = 5'd2;
                end
            end
        endcase
        return k;
    endfunction

    function automatic logic [5:0] start_next(input logic [4:0] k);
        logic [5:0] s;
        case (k)
            5'd0:  s = 6'd1;
            5'd1:  s = 6'd2;
            5'd2:  s = 6'd3;
            5'd3:  s = 6'd4;
            5'd4:  s = 6'd5;
            5'd5:  s = 6'd6;
            5'd6:  s = 6'd11;
            5'd7:  s = 6'd9;
            5'd8:  s = 6'd0;
            5'd9:  s = 6'd25;
            5'd10: s = 6'd30;
            5'd11: s = 6'd31;
            5'd12: s = 6'd32;
            5'd13: s = 6'd23;
            5'd14: s = 6'd24;
            5'd15: s = 6'd21;
            5'd16: s = 6'd22;
            5'd17: s = 6'd33;
            5'd18: s = 6'd34;
            5'd19: s = 6'd35;
            5'd20: s = 6'd36;
            5'd21: s = 6'd37;
            5'd22: s = 6'd38;
            5'd23: s = 6'd39;
            5'd24: s = 6'd26;
            5'd25: s = 6'd27;
            5'd26: s = 6'd18;
            5'd27: s = 6'd19;
            5'd28: s = 6'd20;
            default: s = DS_REJECT;
        endcase
        return s;
    endfunction

    function automatic logic [5:0] next_state(input logic [5:0] s, input logic [4:0] k);
        logic [5:0] n;
        n = DS_REJECT;
        if (k != K_NONE)
        begin
            case (s)
                6'd1: n = start_next(k);
                6'd2: n = (k == 5'd1 || k == 5'd2) ? 6'd2 : DS_REJECT;
                6'd3: n = (k == 5'd2) ? 6'd3 : ((k == 5'd10) ? 6'd8 : DS_REJECT);
                6'd7, 6'd8: n = (k == 5'd2) ? 6'd7 : DS_REJECT;
                6'd9: n = (k == 5'd1) ? 6'd10 : DS_REJECT;
                6'd10: n = (k == 5'd7) ? 6'd16 : DS_REJECT;
                6'd11, 6'd12: n = (k == 5'd1) ? 6'd12 : ((k == 5'd6) ? 6'd17 : DS_REJECT);
                6'd4: n = (k == 5'd5) ? 6'd13 : DS_REJECT;
                6'd5: n = (k == 5'd5) ? 6'd14 : DS_REJECT;
                6'd6: n = (k == 5'd5) ? 6'd15 : DS_REJECT;
                default: n = DS_REJECT;
            endcase
        end
        return n;
    endfunction

    function automatic logic [63:0] kw_word(input int i);
        logic [63:0] w;
        case (i)
            0: w = "int";
            1: w = "main";
            2: w = "void";
            3: w = "if";
            4: w = "else";
            5: w = "char";
            6: w = "double";
            7: w = "enum";
            8: w = "float";
            9: w = "struct";
            10: w = "for";
            11: w = "do";
            12: w = "while";
            13: w = "break";
            14: w = "continue";
            15: w = "goto";
            16: w = "switch";
            17: w = "case";
            18: w = "default";
            19: w = "return";
            20: w = "const";
            21: w = "string";
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic int kw_len(input int i);
        int n;
        case (i)
            3, 11: n = 2;
            0, 10: n = 3;
            1, 2, 4, 5, 7, 15, 17: n = 4;
            8, 12, 13, 20: n = 5;
            6, 9, 16, 19, 21: n = 6;
            18: n = 7;
            14: n = 8;
            default: n = 0;
        endcase
        return n;
    endfunction

    function automatic logic [15:0] punct_word(input int i);
        logic [15:0] w;
        case (i)
            0: w = ">=";
            1: w = "<=";
            2: w = "==";
            3: w = "=";
            4: w = ">";
            5: w = "<";
            6: w = "+";
            7: w = "-";
            8: w = "*";
            9: w = "/";
            10: w = "{";
            11: w = "}";
            12: w = ".";
            13: w = ";";
            14: w = "(";
            15: w = ")";
            16: w = ",";
            17: w = "[";
            18: w = "]";
            19: w = "%";
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic int punct_len(input int i);
        return (i < 3) ? 2 : 1;
    endfunction

endpackage

// ----- hdl/lex_char_if.sv -----
interface lex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

// ----- hdl/lex_token_if.sv -----
interface lex_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_class;
    logic [15:0] token_code;
    logic [30:0] number_value;
    logic [7:0]  literal_byte;
    logic        last;

    modport source (output valid, output token_class, output token_code,
                    output number_value, output literal_byte, output last, input ready);
    modport sink (input valid, input token_class, input token_code,
                  input number_value, input literal_byte, input last, output ready);
endinterface

// ----- hdl/dfa_lexer_with_symbol_table.sv -----
// DFA lexer with identifier symbol table.
// char_ch takes one source byte per beat; token_ch gives one token per beat,
// with last set on the final token caused by a byte (a byte causes at most two).
// A byte that extends the current token, is skipped whitespace or is the '#'
// end mark is taken in ST_IDLE and gives no token.
// A byte that ends a keyword, punctuator, number, char constant or string
// token goes through ST_CLASS to the token beat on token_ch in ST_OUT.
// An identifier token walks the symbol table memory one entry at a time
// (read in ST_RD, then compare in ST_CMP) over the N entries in use.
// A byte that the start state rejects gives one error beat in the next cycle.
// char_ch stays not ready from the accepted byte until its last token beat
// has been taken; a stall on token_ch holds the beat and the block.
// Reset empties the token, clears all counters and the table count, and puts
// the DFA in its start state; table contents need no clearing pass.
`include "dfa_lexer_with_symbol_table_defines.svh"

module dfa_lexer_with_symbol_table
    import dlx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lex_char_if.sink    char_ch,
    lex_token_if.source token_ch
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLASS = 5'b00010,
        ST_RD    = 5'b00100,
        ST_CMP   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    localparam logic [34:0] SAT_VALUE = 35'h7FFF_FFFF;

    state_t           state_reg, state_next;
    logic [5:0]       scan_reg, scan_next;
    logic [7:0]       tok_reg [MAX_TOKEN_CHARS];
    logic [7:0]       tok_next [MAX_TOKEN_CHARS];
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic [30:0]      acc_reg, acc_next;
    logic [CNT_W-1:0] id_cnt_reg, id_cnt_next;
    logic [CNT_W-1:0] srch_reg, srch_next;
    logic [15:0]      num_cnt_reg, num_cnt_next;
    logic [15:0]      chr_cnt_reg, chr_cnt_next;
    logic [15:0]      str_cnt_reg, str_cnt_next;
    logic             second_reg, second_next;
    logic             out_valid_reg, out_valid_next;
    logic [5:0]       pend_st_reg, pend_st_next;
    logic [4:0]       pend_k_reg, pend_k_next;
    logic [7:0]       pend_c_reg, pend_c_next;
    logic [2:0]       out_cls_reg, out_cls_next;
    logic [15:0]      out_code_reg, out_code_next;
    logic [30:0]      out_num_reg, out_num_next;
    logic [7:0]       out_lit_reg, out_lit_next;
    logic             out_last_reg, out_last_next;

    logic [ENTRY_W-1:0] id_mem [IDENT_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic               mem_we;

    logic [4:0]  in_k;
    logic [5:0]  in_nxt;
    logic        app_en, app_clear;
    logic [7:0]  app_c;
    logic [5:0]  app_st;
    logic [LEN_W-1:0] base_len;
    logic [30:0] base_acc;
    logic        base_ovf;
    logic [34:0] acc_wide;
    logic        res_load;
    logic [2:0]  res_cls;
    logic [15:0] res_code;
    logic [30:0] res_num;
    logic [7:0]  res_lit;
    logic        kw_hit, pu_hit, id_eq;
    logic [15:0] kw_code, pu_code;
    logic [5:0]  restart_st;
    logic        new_ident, found_ident;
    logic [CNT_W-1:0] srch_inc;

    assign char_ch.ready         = (state_reg == ST_IDLE);
    assign token_ch.valid        = out_valid_reg;
    assign token_ch.token_class  = out_cls_reg;
    assign token_ch.token_code   = out_code_reg;
    assign token_ch.number_value = out_num_reg;
    assign token_ch.literal_byte = out_lit_reg;
    assign token_ch.last         = out_last_reg;

    assign in_k       = char_class(char_ch.char_in);
    assign in_nxt     = next_state(scan_reg, in_k);
    assign restart_st = start_next(pend_k_reg);
    assign srch_inc   = srch_reg + CNT_W'(1);
    assign mem_raddr  = srch_reg[IDX_W-1:0];

    always_comb
    begin
        kw_hit  = 1'b0;
        kw_code = '0;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            logic eq;
            int   l;
            logic [63:0] w;
            w  = kw_word(i);
            l  = kw_len(i);
            eq = (int'(len_reg) == l) && (l <= MAX_TOKEN_CHARS);
            for (int j = 0; j < 8; j++)
            begin
                if (j < l && j < MAX_TOKEN_CHARS)
                begin
                    if (w[8 * (l - 1 - j) +: 8] != tok_reg[j])
                    begin
                        eq = 1'b0;
                    end
                end
            end
            if (eq && !kw_hit)
            begin
                kw_hit  = 1'b1;
                kw_code = 16'(i + 1);
            end
        end
    end

    always_comb
    begin
        pu_hit  = 1'b0;
        pu_code = '0;
        for (int i = 0; i < PUNCT_COUNT; i++)
        begin
            logic eq;
            int   l;
            logic [15:0] w;
            w  = punct_word(i);
            l  = punct_len(i);
            eq = (int'(len_reg) == l);
            for (int j = 0; j < 2; j++)
            begin
                if (j < l)
                begin
                    if (w[8 * (l - 1 - j) +: 8] != tok_reg[j])
                    begin
                        eq = 1'b0;
                    end
                end
            end
            if (eq && !pu_hit)
            begin
                pu_hit  = 1'b1;
                pu_code = 16'(i + 1);
            end
        end
    end

    always_comb
    begin
        id_eq = (rd_data_reg[ENTRY_W-1 -: LEN_W] == len_reg);
        for (int j = 0; j < MAX_TOKEN_CHARS; j++)
        begin
            if (j < int'(len_reg) && rd_data_reg[8 * j +: 8] != tok_reg[j])
            begin
                id_eq = 1'b0;
            end
        end
        mem_wdata[ENTRY_W-1 -: LEN_W] = len_reg;
        for (int j = 0; j < MAX_TOKEN_CHARS; j++)
        begin
            mem_wdata[8 * j +: 8] = tok_reg[j];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        id_cnt_next    = id_cnt_reg;
        srch_next      = srch_reg;
        num_cnt_next   = num_cnt_reg;
        chr_cnt_next   = chr_cnt_reg;
        str_cnt_next   = str_cnt_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg;
        pend_st_next   = pend_st_reg;
        pend_k_next    = pend_k_reg;
        pend_c_next    = pend_c_reg;
        out_cls_next   = out_cls_reg;
        out_code_next  = out_code_reg;
        out_num_next   = out_num_reg;
        out_lit_next   = out_lit_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        app_en         = 1'b0;
        app_clear      = 1'b0;
        app_c          = char_ch.char_in;
        app_st         = in_nxt;
        res_load       = 1'b0;
        res_cls        = CLS_ERROR;
        res_code       = '0;
        res_num        = '0;
        res_lit        = '0;
        new_ident      = 1'b0;
        found_ident    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (char_ch.valid)
                begin
                    if (char_ch.char_in == END_MARK)
                    begin
                        scan_next = DS_START;
                        app_clear = 1'b1;
                    end
                    else if (scan_reg == DS_START && in_nxt == DS_START)
                    begin
                        scan_next = scan_reg;
                    end
                    else if (in_nxt != DS_REJECT)
                    begin
                        app_en    = 1'b1;
                        scan_next = in_nxt;
                    end
                    else if (scan_reg == DS_START)
                    begin
                        out_valid_next = 1'b1;
                        out_cls_next   = CLS_ERROR;
                        out_code_next  = '0;
                        out_num_next   = '0;
                        out_lit_next   = '0;
                        out_last_next  = 1'b1;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        pend_st_next = scan_reg;
                        pend_k_next  = in_k;
                        pend_c_next  = char_ch.char_in;
                        state_next   = ST_CLASS;
                    end
                end
            end
            ST_CLASS:
            begin
                if (ovf_reg)
                begin
                    res_load = 1'b1;
                end
                else if (kw_hit)
                begin
                    res_load = 1'b1;
                    res_cls  = CLS_KEYWORD;
                    res_code = kw_code;
                end
                else if (pu_hit)
                begin
                    res_load = 1'b1;
                    res_cls  = CLS_PUNCT;
                    res_code = pu_code;
                end
                else if (pend_st_reg == DS_IDENT)
                begin
                    srch_next = '0;
                    if (id_cnt_reg == '0)
                    begin
                        new_ident = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
                else if (pend_st_reg == DS_INT || pend_st_reg == DS_FRAC)
                begin
                    num_cnt_next = num_cnt_reg + 16'd1;
                    res_load = 1'b1;
                    res_cls  = CLS_NUMBER;
                    res_code = num_cnt_reg + 16'd1;
                    res_num  = acc_reg;
                end
                else if (pend_st_reg == DS_CHAR_END)
                begin
                    chr_cnt_next = chr_cnt_reg + 16'd1;
                    res_load = 1'b1;
                    res_cls  = CLS_CHAR;
                    res_code = chr_cnt_reg + 16'd1;
                    res_lit  = (len_reg > LEN_W'(1)) ? tok_reg[1] : 8'd0;
                end
                else if (pend_st_reg == DS_STR_END)
                begin
                    str_cnt_next = str_cnt_reg + 16'd1;
                    res_load = 1'b1;
                    res_cls  = CLS_STRING;
                    res_code = str_cnt_reg + 16'd1;
                end
                else
                begin
                    res_load = 1'b1;
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (id_eq)
                begin
                    found_ident = 1'b1;
                end
                else if (srch_inc == id_cnt_reg)
                begin
                    new_ident = 1'b1;
                end
                else
                begin
                    srch_next  = srch_inc;
                    state_next = ST_RD;
                end
            end
            ST_OUT:
            begin
                if (token_ch.ready)
                begin
                    if (second_reg)
                    begin
                        second_next   = 1'b0;
                        out_cls_next  = CLS_ERROR;
                        out_code_next = '0;
                        out_num_next  = '0;
                        out_lit_next  = '0;
                        out_last_next = 1'b1;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (found_ident)
        begin
            res_load = 1'b1;
            res_cls  = CLS_IDENT;
            res_code = 16'(srch_inc);
        end
        if (new_ident)
        begin
            res_load = 1'b1;
            if (id_cnt_reg < CNT_W'(IDENT_ENTRIES))
            begin
                mem_we      = 1'b1;
                id_cnt_next = id_cnt_reg + CNT_W'(1);
                res_cls     = CLS_IDENT;
                res_code    = 16'(id_cnt_reg + CNT_W'(1));
            end
        end

        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_cls_next   = res_cls;
            out_code_next  = res_code;
            out_num_next   = res_num;
            out_lit_next   = res_lit;
            state_next     = ST_OUT;
            scan_next      = DS_START;
            app_clear      = 1'b1;
            app_c          = pend_c_reg;
            app_st         = restart_st;
            second_next    = 1'b0;
            if (pend_k_reg != K_SPACE)
            begin
                if (restart_st == DS_REJECT)
                begin
                    second_next = 1'b1;
                end
                else
                begin
                    app_en    = 1'b1;
                    scan_next = restart_st;
                end
            end
            out_last_next = !second_next;
        end
    end

    always_comb
    begin
        base_len = app_clear ? '0 : len_reg;
        base_acc = app_clear ? '0 : acc_reg;
        base_ovf = app_clear ? 1'b0 : ovf_reg;
        acc_wide = ({4'd0, base_acc} << 3) + ({4'd0, base_acc} << 1) + 35'(app_c[3:0]);
        tok_next = tok_reg;
        len_next = base_len;
        ovf_next = base_ovf;
        acc_next = base_acc;
        if (app_en)
        begin
            if (base_len < LEN_W'(MAX_TOKEN_CHARS))
            begin
                for (int j = 0; j < MAX_TOKEN_CHARS; j++)
                begin
                    if (LEN_W'(j) == base_len)
                    begin
                        tok_next[j] = app_c;
                    end
                end
                len_next = base_len + LEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (app_st == DS_INT)
            begin
                acc_next = (acc_wide > SAT_VALUE) ? SAT_VALUE[30:0] : acc_wide[30:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= DS_START;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            acc_reg       <= '0;
            id_cnt_reg    <= '0;
            srch_reg      <= '0;
            num_cnt_reg   <= '0;
            chr_cnt_reg   <= '0;
            str_cnt_reg   <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            acc_reg       <= acc_next;
            id_cnt_reg    <= id_cnt_next;
            srch_reg      <= srch_next;
            num_cnt_reg   <= num_cnt_next;
            chr_cnt_reg   <= chr_cnt_next;
            str_cnt_reg   <= str_cnt_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg      <= tok_next;
        pend_st_reg  <= pend_st_next;
        pend_k_reg   <= pend_k_next;
        pend_c_reg   <= pend_c_next;
        out_cls_reg  <= out_cls_next;
        out_code_reg <= out_code_next;
        out_num_reg  <= out_num_next;
        out_lit_reg  <= out_lit_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[id_cnt_reg[IDX_W-1:0]] <= mem_wdata;
        end
        rd_data_reg <= id_mem[mem_raddr];
    end

    `DLX_ASSERT(a_valid_in_out, !token_ch.valid || state_reg == ST_OUT)
    `DLX_ASSERT(a_cnt_bound, id_cnt_reg <= CNT_W'(IDENT_ENTRIES))
    `DLX_ASSERT(a_srch_bound, !(state_reg == ST_RD || state_reg == ST_CMP) || srch_reg < id_cnt_reg)
    `DLX_ASSERT_NEXT(a_rd_then_cmp, state_reg == ST_RD, state_reg == ST_CMP)

endmodule
